[hw/rtl/klpd_pkg.sv]
// ============================================================================
// klpd_pkg - keypad long press detector package
// Codes, reset values and the key code decoder shared by the detector.
// ============================================================================
package klpd_pkg;

   localparam int NUM_KEYS_DEF  = 22;
   localparam int HOLD_KEYS_DEF = 20;

   localparam logic [15:0] THRESHOLD_RESET = 16'd500;

   localparam logic        OP_POLL     = 1'b0;
   localparam logic        OP_EVENT    = 1'b1;
   localparam logic [15:0] EV_TYPE_KEY = 16'd1;

   localparam logic [1:0] VAL_RELEASE = 2'd0;
   localparam logic [1:0] VAL_PRESS   = 2'd1;

   localparam logic [1:0] KIND_PRESS   = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_HOLD    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVENT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] id;
   } key_map_type;

   function automatic key_map_type map_code(input logic [15:0] code);
      key_map_type m;
      m.hit = 1'b1;
      unique case (code) inside
         16'd82,  16'd512:          m.id = 5'd0;
         16'd79,  16'd513:          m.id = 5'd1;
         16'd80,  16'd514:          m.id = 5'd2;
         16'd81,  16'd515:          m.id = 5'd3;
         16'd75,  16'd516:          m.id = 5'd4;
         16'd76,  16'd517:          m.id = 5'd5;
         16'd77,  16'd518:          m.id = 5'd6;
         16'd71,  16'd519:          m.id = 5'd7;
         16'd72,  16'd520:          m.id = 5'd8;
         16'd73,  16'd521:          m.id = 5'd9;
         16'd522:                   m.id = 5'd10;
         16'd523:                   m.id = 5'd11;
         16'd103:                   m.id = 5'd12;
         16'd108:                   m.id = 5'd13;
         16'd105:                   m.id = 5'd14;
         16'd106:                   m.id = 5'd15;
         16'd28, 16'd96, 16'd353:   m.id = 5'd16;
         16'd231, 16'd169:          m.id = 5'd17;
         16'd107, 16'd116:          m.id = 5'd18;
         16'd158, 16'd1:            m.id = 5'd19;
         16'd59,  16'd139:          m.id = 5'd20;
         16'd60,  16'd438:          m.id = 5'd21;
         default: begin
            m.hit = 1'b0;
            m.id  = 5'd0;
         end
      endcase
      return m;
   endfunction

endpackage

[hw/rtl/keypad_long_press_detector_top.sv]
// ============================================================================
// keypad_long_press_detector_top - keypad long press detector
// Reports key press, release and hold words from raw key events and polls.
// ----------------------------------------------------------------------------
// req_* carries one word per poll or raw event; rsp_* returns exactly one word
// for each accepted req word, rsp_out_valid telling whether an event is in it.
// Both channels use valid/stall; csr_write_enable loads the hold threshold.
// After a req word is taken the block scans the hold-capable keys, one press
// stamp memory read and one elapsed-time compare per cycle, with the compare
// in the cycle after the read. A hold found at key k ends the scan early.
// Without a hold the scan covers all min(HOLD_KEYS,NUM_KEYS) hold-capable
// keys and the raw event is then handled in ST_EVENT; after the rsp word is
// taken the block returns to idle before it accepts the next req word.
// req_stall is high from accept until the rsp word is taken; while the
// receiver stalls, the rsp word holds and no new req word is accepted.
// Synchronous reset clears all held bits, the threshold returns to 500 ms and
// the block goes idle; press stamps are not cleared since they are read only
// for keys whose held bit is set.
// ============================================================================
module keypad_long_press_detector_top #(
   parameter int NUM_KEYS  = klpd_pkg::NUM_KEYS_DEF,
   parameter int HOLD_KEYS = klpd_pkg::HOLD_KEYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_event_type,
   input  logic [15:0] req_key_code,
   input  logic [1:0]  req_key_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_valid,
   output logic [4:0]  rsp_key_id,
   output logic [1:0]  rsp_event_kind,
   output logic [31:0] rsp_stamp_ms,
   output logic        rsp_input_taken
);

   localparam int HOLD_LIM = (HOLD_KEYS < NUM_KEYS) ? HOLD_KEYS : NUM_KEYS;
   localparam int IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam logic [IDX_W-1:0] HOLD_LAST = IDX_W'(HOLD_LIM - 1);

   klpd_pkg::state_type state_ff, state_in;

   logic [15:0]         thr_ff;
   logic [NUM_KEYS-1:0] held_ff, held_in;

   logic        op_ff;
   logic [31:0] now_ff;
   logic [15:0] type_ff;
   logic [15:0] code_ff;
   logic [1:0]  value_ff;

   logic [IDX_W-1:0] issue_ff, issue_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_vld_ff;
   logic [31:0]      stamp_rd_ff;
   logic [31:0]      stamp_mem [NUM_KEYS];

   logic        rsp_out_valid_ff, rsp_out_valid_in;
   logic [4:0]  rsp_key_id_ff, rsp_key_id_in;
   logic [1:0]  rsp_event_kind_ff, rsp_event_kind_in;
   logic [31:0] rsp_stamp_ms_ff, rsp_stamp_ms_in;
   logic        rsp_input_taken_ff, rsp_input_taken_in;

   logic                 accept;
   logic [31:0]          elapsed;
   logic                 hold_hit;
   logic                 scan_last;
   klpd_pkg::key_map_type kmap;
   logic                 key_ok;
   logic                 ev_press;
   logic                 ev_release;
   logic [IDX_W-1:0]     key_idx;
   logic                 stamp_we;

   assign accept = req_valid && !req_stall;

   // shared elapsed-time unit
   assign elapsed   = now_ff - stamp_rd_ff;
   assign hold_hit  = cmp_vld_ff && held_ff[cmp_idx_ff] && (elapsed >= {16'd0, thr_ff});
   assign scan_last = cmp_vld_ff && (cmp_idx_ff == HOLD_LAST);

   assign kmap       = klpd_pkg::map_code(code_ff);
   assign key_ok     = (op_ff == klpd_pkg::OP_EVENT) && (type_ff == klpd_pkg::EV_TYPE_KEY)
                       && kmap.hit && ({2'd0, kmap.id} < 7'(NUM_KEYS));
   assign ev_press   = key_ok && (value_ff == klpd_pkg::VAL_PRESS);
   assign ev_release = key_ok && (value_ff == klpd_pkg::VAL_RELEASE);
   assign key_idx    = IDX_W'(kmap.id);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         klpd_pkg::ST_IDLE: begin
            if (accept) state_in = klpd_pkg::ST_SCAN;
         end
         klpd_pkg::ST_SCAN: begin
            if (hold_hit) state_in = klpd_pkg::ST_DONE;
            else if (scan_last) state_in = klpd_pkg::ST_EVENT;
         end
         klpd_pkg::ST_EVENT: begin
            state_in = klpd_pkg::ST_DONE;
         end
         klpd_pkg::ST_DONE: begin
            if (!rsp_stall) state_in = klpd_pkg::ST_IDLE;
         end
         default: state_in = klpd_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall          = (state_ff != klpd_pkg::ST_IDLE);
      rsp_valid          = (state_ff == klpd_pkg::ST_DONE);
      issue_in           = issue_ff;
      held_in            = held_ff;
      stamp_we           = 1'b0;
      rsp_out_valid_in   = rsp_out_valid_ff;
      rsp_key_id_in      = rsp_key_id_ff;
      rsp_event_kind_in  = rsp_event_kind_ff;
      rsp_stamp_ms_in    = rsp_stamp_ms_ff;
      rsp_input_taken_in = rsp_input_taken_ff;
      unique case (state_ff)
         klpd_pkg::ST_IDLE: begin
            issue_in = '0;
         end
         klpd_pkg::ST_SCAN: begin
            if (issue_ff != HOLD_LAST) issue_in = issue_ff + 1'b1;
            if (hold_hit) begin
               held_in[cmp_idx_ff] = 1'b0;
               rsp_out_valid_in    = 1'b1;
               rsp_key_id_in       = 5'(cmp_idx_ff);
               rsp_event_kind_in   = klpd_pkg::KIND_HOLD;
               rsp_stamp_ms_in     = now_ff;
               rsp_input_taken_in  = (op_ff == klpd_pkg::OP_POLL);
            end
         end
         klpd_pkg::ST_EVENT: begin
            rsp_out_valid_in   = ev_press || ev_release;
            rsp_key_id_in      = (ev_press || ev_release) ? kmap.id : 5'd0;
            rsp_event_kind_in  = ev_release ? klpd_pkg::KIND_RELEASE : klpd_pkg::KIND_PRESS;
            rsp_stamp_ms_in    = (ev_press || ev_release) ? now_ff : 32'd0;
            rsp_input_taken_in = 1'b1;
            if (ev_press) begin
               held_in[key_idx] = 1'b1;
               stamp_we         = 1'b1;
            end else if (ev_release) begin
               held_in[key_idx] = 1'b0;
            end
         end
         klpd_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= klpd_pkg::ST_IDLE;
         thr_ff     <= klpd_pkg::THRESHOLD_RESET;
         held_ff    <= '0;
         issue_ff   <= '0;
         cmp_idx_ff <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         held_ff    <= held_in;
         issue_ff   <= issue_in;
         cmp_idx_ff <= issue_ff;
         cmp_vld_ff <= (state_ff == klpd_pkg::ST_SCAN) && !hold_hit && !scan_last;
         if (csr_write_enable) thr_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         now_ff   <= req_now_ms;
         type_ff  <= req_event_type;
         code_ff  <= req_key_code;
         value_ff <= req_key_value;
      end
      rsp_out_valid_ff   <= rsp_out_valid_in;
      rsp_key_id_ff      <= rsp_key_id_in;
      rsp_event_kind_ff  <= rsp_event_kind_in;
      rsp_stamp_ms_ff    <= rsp_stamp_ms_in;
      rsp_input_taken_ff <= rsp_input_taken_in;
   end

   // press stamp memory
   always_ff @(posedge clock) begin
      if (stamp_we) stamp_mem[key_idx] <= now_ff;
      stamp_rd_ff <= stamp_mem[issue_ff];
   end

   assign rsp_out_valid   = rsp_out_valid_ff;
   assign rsp_key_id      = rsp_key_id_ff;
   assign rsp_event_kind  = rsp_event_kind_ff;
   assign rsp_stamp_ms    = rsp_stamp_ms_ff;
   assign rsp_input_taken = rsp_input_taken_ff;

   // no new word while a result is pending
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req accepted while rsp pending");

   // holds only come from hold-capable keys
   a_hold_key_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid && rsp_event_kind == klpd_pkg::KIND_HOLD)
      |-> ({3'd0, rsp_key_id} < 8'(HOLD_LIM)))
      else $error("hold on key outside hold range");

   // deferred input only with a hold word
   a_defer_only_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_input_taken)
      |-> (rsp_out_valid && rsp_event_kind == klpd_pkg::KIND_HOLD))
      else $error("input deferred without hold");

   // empty word carries zero fields
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_valid)
      |-> (rsp_key_id == 5'd0 && rsp_stamp_ms == 32'd0 && rsp_input_taken))
      else $error("empty rsp word not cleared");

   // a hold clears the held bit of its key
   a_hold_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == klpd_pkg::ST_SCAN && hold_hit) |=> !held_ff[$past(cmp_idx_ff)])
      else $error("held bit not cleared by hold");

endmodule

[sim/keypad_long_press_detector_top_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// keypad_long_press_detector_top_tb - keypad long press detector testbench
// A driver pushes poll and raw key event words from a queue; a monitor checks
// each returned word against an in-bench model of the press/hold/release
// tracking. Both sides idle at random, and every deferred event is resent.
// The hold threshold is changed between phases, including 0 and 65535.
// ============================================================================
module keypad_long_press_detector_top_tb;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          PRINT_LIMIT = 50;
   localparam logic [1:0]  VAL_REPEAT  = 2'd2;
   localparam logic [1:0]  VAL_OTHER   = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [31:0] now_ms;
      logic [15:0] ev_type;
      logic [15:0] code;
      logic [1:0]  value;
   } key_word_type;

   typedef struct packed {
      logic        out_valid;
      logic [4:0]  key_id;
      logic [1:0]  kind;
      logic [31:0] stamp;
      logic        taken;
   } key_report_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data   = 16'd0;
   logic        req_valid        = 1'b0;
   key_word_type req_word        = '0;
   logic        rsp_stall        = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_out_valid;
   logic [4:0]  rsp_key_id;
   logic [1:0]  rsp_event_kind;
   logic [31:0] rsp_stamp_ms;
   logic        rsp_input_taken;

   // model state
   logic [15:0]                       hold_ms = klpd_pkg::THRESHOLD_RESET;
   logic [klpd_pkg::NUM_KEYS_DEF-1:0] held_mask = '0;
   logic [31:0]                       down_since [klpd_pkg::NUM_KEYS_DEF];
   logic [4:0]                        key_for_code [int];
   logic [15:0]                       code_pool [$];

   key_word_type   pending_words [$];
   key_report_type expected_rsp [$];

   logic        no_idle = 1'b0;
   logic [31:0] sim_ms;
   int          gap_left, stall_left;
   int          cycle_count, mismatches, rsp_seen, words_sent, resent;
   int          presses, releases, holds, quiet_words;
   key_report_type sent_report, want;

   keypad_long_press_detector_top u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_word.opcode),
      .req_now_ms       (req_word.now_ms),
      .req_event_type   (req_word.ev_type),
      .req_key_code     (req_word.code),
      .req_key_value    (req_word.value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_key_id       (rsp_key_id),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_stamp_ms     (rsp_stamp_ms),
      .rsp_input_taken  (rsp_input_taken)
   );

   always #6 clock = ~clock;

   function automatic void add_key(input int id, input int code);
      key_for_code[code] = id[4:0];
      code_pool.push_back(code[15:0]);
   endfunction

   function automatic key_word_type make_word(input logic op, input logic [31:0] t,
                                              input logic [15:0] ty, input logic [15:0] c,
                                              input logic [1:0] v);
      key_word_type w;
      w.opcode  = op;
      w.now_ms  = t;
      w.ev_type = ty;
      w.code    = c;
      w.value   = v;
      return w;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // hold scan first, then the raw event if no hold fired
   function automatic key_report_type predict_keypad(input key_word_type w);
      key_report_type o;
      int             k;
      logic [4:0]     id;
      o = '{out_valid: 1'b0, key_id: 5'd0, kind: 2'd0, stamp: 32'd0, taken: 1'b1};
      for (k = 0; k < klpd_pkg::HOLD_KEYS_DEF && k < klpd_pkg::NUM_KEYS_DEF; k++) begin
         if (held_mask[k] && (w.now_ms - down_since[k]) >= {16'd0, hold_ms}) begin
            held_mask[k] = 1'b0;
            o.out_valid  = 1'b1;
            o.key_id     = k[4:0];
            o.kind       = klpd_pkg::KIND_HOLD;
            o.stamp      = w.now_ms;
            o.taken      = (w.opcode == klpd_pkg::OP_POLL);
            return o;
         end
      end
      if (w.opcode != klpd_pkg::OP_EVENT || w.ev_type != klpd_pkg::EV_TYPE_KEY
          || !key_for_code.exists(int'(w.code)))
         return o;
      id = key_for_code[int'(w.code)];
      if (id >= klpd_pkg::NUM_KEYS_DEF)
         return o;
      if (w.value == klpd_pkg::VAL_PRESS) begin
         down_since[id] = w.now_ms;
         held_mask[id]  = 1'b1;
         o.kind         = klpd_pkg::KIND_PRESS;
      end else if (w.value == klpd_pkg::VAL_RELEASE) begin
         held_mask[id] = 1'b0;
         o.kind        = klpd_pkg::KIND_RELEASE;
      end else begin
         return o;
      end
      o.out_valid = 1'b1;
      o.key_id    = id;
      o.stamp     = w.now_ms;
      return o;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint exp_val);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("ERROR: rsp word %0d %s: got 0x%0h, want 0x%0h",
                  rsp_seen, field, got, exp_val);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      hold_ms          <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // mostly time-ordered press/release/poll traffic, some raw noise
   task automatic queue_phase(input int words);
      int           made, pick, r;
      int unsigned  span, step;
      key_word_type w;
      made = 0;
      span = 32'(hold_ms) + 2;
      while (made < words) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            w = make_word(1'($urandom_range(0, 1)), $urandom(), 16'($urandom()),
                          16'($urandom()), 2'($urandom()));
            if (pick < 5) begin
               w.ev_type = klpd_pkg::EV_TYPE_KEY;
            end else if (pick < 9) begin
               w.opcode  = klpd_pkg::OP_EVENT;
               w.ev_type = klpd_pkg::EV_TYPE_KEY;
               w.code    = code_pool[$urandom_range(0, code_pool.size() - 1)];
               w.value   = $urandom_range(0, 1) ? VAL_REPEAT : VAL_OTHER;
            end
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70)
               step = $urandom_range(0, span / 3);
            else if (r < 97)
               step = $urandom_range(span / 2, span * 2);
            else
               step = $urandom();
            sim_ms = sim_ms + step;
            if (pick < 35) begin
               w = make_word(klpd_pkg::OP_POLL, sim_ms, 16'($urandom()), 16'($urandom()),
                             2'($urandom()));
            end else begin
               w = make_word(klpd_pkg::OP_EVENT, sim_ms, klpd_pkg::EV_TYPE_KEY,
                             code_pool[$urandom_range(0, code_pool.size() - 1)],
                             ($urandom_range(0, 9) < 6) ? klpd_pkg::VAL_PRESS
                                                        : klpd_pkg::VAL_RELEASE);
            end
            made++;
         end
         pending_words.push_back(w);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_word  <= '0;
         gap_left  = 0;
         held_mask = '0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            sent_report = predict_keypad(req_word);
            expected_rsp.push_back(sent_report);
            words_sent++;
            if (!sent_report.taken) begin
               pending_words.push_front(req_word);
               resent++;
            end
            gap_left = pick_gap();
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_word  <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("word with none expected", rsp_out_valid, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_out_valid !== want.out_valid)
                  report_mismatch("out_valid", rsp_out_valid, want.out_valid);
               if (rsp_key_id !== want.key_id)
                  report_mismatch("key_id", rsp_key_id, want.key_id);
               if (rsp_event_kind !== want.kind)
                  report_mismatch("event_kind", rsp_event_kind, want.kind);
               if (rsp_stamp_ms !== want.stamp)
                  report_mismatch("stamp_ms", rsp_stamp_ms, want.stamp);
               if (rsp_input_taken !== want.taken)
                  report_mismatch("input_taken", rsp_input_taken, want.taken);
               if (!want.out_valid)
                  quiet_words++;
               else if (want.kind == klpd_pkg::KIND_PRESS)
                  presses++;
               else if (want.kind == klpd_pkg::KIND_RELEASE)
                  releases++;
               else
                  holds++;
            end
         end
         if (stall_left == 0)
            stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  expected_rsp.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int          phase;
      logic [15:0] thr;
      add_key(0, 82);   add_key(0, 512);  add_key(1, 79);   add_key(1, 513);
      add_key(2, 80);   add_key(2, 514);  add_key(3, 81);   add_key(3, 515);
      add_key(4, 75);   add_key(4, 516);  add_key(5, 76);   add_key(5, 517);
      add_key(6, 77);   add_key(6, 518);  add_key(7, 71);   add_key(7, 519);
      add_key(8, 72);   add_key(8, 520);  add_key(9, 73);   add_key(9, 521);
      add_key(10, 522); add_key(11, 523); add_key(12, 103); add_key(13, 108);
      add_key(14, 105); add_key(15, 106); add_key(16, 28);  add_key(16, 96);
      add_key(16, 353); add_key(17, 231); add_key(17, 169); add_key(18, 107);
      add_key(18, 116); add_key(19, 158); add_key(19, 1);   add_key(20, 59);
      add_key(20, 139); add_key(21, 60);  add_key(21, 438);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset threshold: hold edge, release of keys not held, soft keys,
      // deferred events, timer restart, ignored words, time wrap
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'd0, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd1000, klpd_pkg::EV_TYPE_KEY,
                                        16'd82, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'd1499, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'd1500, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd1510, klpd_pkg::EV_TYPE_KEY,
                                        16'd512, klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd1600, klpd_pkg::EV_TYPE_KEY,
                                        16'd59, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'd9000, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd9000, klpd_pkg::EV_TYPE_KEY,
                                        16'd438, klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd9001, klpd_pkg::EV_TYPE_KEY,
                                        16'd139, klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd10000, klpd_pkg::EV_TYPE_KEY,
                                        16'd1, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd10010, klpd_pkg::EV_TYPE_KEY,
                                        16'd517, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd10600, klpd_pkg::EV_TYPE_KEY,
                                        16'd103, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd10800, klpd_pkg::EV_TYPE_KEY,
                                        16'd103, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'd11250, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'd11300, 16'hFFFF, 16'hFFFF,
                                        VAL_OTHER));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd11400, 16'hFFFF, 16'd82,
                                        klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd11400, klpd_pkg::EV_TYPE_KEY,
                                        16'hFFFF, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd11400, klpd_pkg::EV_TYPE_KEY,
                                        16'd82, VAL_REPEAT));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd11400, klpd_pkg::EV_TYPE_KEY,
                                        16'd82, VAL_OTHER));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'd11400, klpd_pkg::EV_TYPE_KEY,
                                        16'd82, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'hFFFF_FF00,
                                        klpd_pkg::EV_TYPE_KEY, 16'd73, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'h0000_00F3, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'h0000_00F4, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      wait_idle();

      // zero threshold: a held key fires on the very next word
      write_threshold(16'd0);
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd5, klpd_pkg::EV_TYPE_KEY,
                                        16'd522, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'd5, klpd_pkg::EV_TYPE_KEY,
                                        16'd523, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'd5, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      wait_idle();

      write_threshold(16'hFFFF);
      pending_words.push_back(make_word(klpd_pkg::OP_EVENT, 32'hFFFF_FFFF,
                                        klpd_pkg::EV_TYPE_KEY, 16'd231, klpd_pkg::VAL_PRESS));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'h0000_FFFD, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      pending_words.push_back(make_word(klpd_pkg::OP_POLL, 32'h0000_FFFE, 16'd0, 16'd0,
                                        klpd_pkg::VAL_RELEASE));
      wait_idle();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: thr = klpd_pkg::THRESHOLD_RESET;
            1: thr = 16'd0;
            2: thr = 16'hFFFF;
            3: thr = 16'd1;
            4: thr = 16'($urandom());
            default: thr = 16'($urandom_range(2, 2000));
         endcase
         write_threshold(thr);
         no_idle = (phase == 2 || phase == 5);
         sim_ms  = (phase == 3) ? 32'hFFFF_FF80 : $urandom();
         queue_phase(52);
         wait_idle();
      end
      no_idle = 1'b0;

      repeat (40) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("words never returned", expected_rsp.size(), 0);
      $display("Sent %0d words (%0d resent after a deferring hold) across thresholds 0..65535.",
               words_sent, resent);
      $display("Checked %0d presses, %0d releases, %0d holds and %0d empty words, %0d errors.",
               presses, releases, holds, quiet_words, mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
